// ----- rtl/ttl_kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// TTL key/value table package
// Shared sizes, status codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ttl_kvt_pkg;

   // Table geometry.
   localparam int SLOTS         = 16;
   localparam int KEY_BITS      = 64;
   localparam int VALUE_BYTES   = 8;
   localparam int VALUE_BITS    = 8 * VALUE_BYTES;
   localparam int SLOT_IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_BITS    = $clog2(SLOTS + 1);

   // Port field widths.
   localparam int KEY_FIELD_BITS   = 64;
   localparam int DATA_FIELD_BITS  = 64;
   localparam int BYTES_BITS       = 4;
   localparam int TIME_BITS        = 32;
   localparam int EXPIRY_BITS      = TIME_BITS + 1;
   localparam int STATUS_BITS      = 3;
   localparam int ENTRY_COUNT_BITS = 5;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_REG_TTL = 1'b0;

   // Request modes.
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_ADDED   = 3'd0,
      STATUS_HIT     = 3'd1,
      STATUS_MISS    = 3'd2,
      STATUS_EXPIRED = 3'd3,
      STATUS_FULL    = 3'd4,
      STATUS_INVALID = 3'd5
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic advance;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finish;
      logic out_free;
   } dp_stat_type;

   // Keep only the low byte_count bytes of a data word.
   function automatic logic [VALUE_BITS-1:0] byte_mask(input logic [BYTES_BITS-1:0] byte_count);
      logic [VALUE_BITS-1:0] mask;
      mask = '0;
      for (int b = 0; b < VALUE_BYTES; b++) begin
         if (BYTES_BITS'(b) < byte_count) begin
            mask[8*b +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

// ----- rtl/ttl_kvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// TTL key/value table controller
// Takes a request beat, steps the datapath through the slots one per cycle
// and commits the outcome once the result register can take it.
// ----------------------------------------------------------------------------
module ttl_kvt_ctrl import ttl_kvt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.finish) begin
               // Hold on the current slot until the result register is free.
               if (stat.out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/ttl_kvt_dp.sv -----
// ----------------------------------------------------------------------------
// TTL key/value table datapath
// Holds the request, the slot store, the entry count and the result
// register, and evaluates one slot per cycle for the controller.
// ----------------------------------------------------------------------------
module ttl_kvt_dp import ttl_kvt_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_cmd_type                cmd,
   output dp_stat_type                 stat,
   input  logic                        req_mode,
   input  logic [KEY_FIELD_BITS-1:0]   req_lookup_key,
   input  logic [DATA_FIELD_BITS-1:0]  req_data_word,
   input  logic [BYTES_BITS-1:0]       req_value_bytes,
   input  logic [TIME_BITS-1:0]        req_now_time,
   input  logic [TIME_BITS-1:0]        ttl_seconds,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [DATA_FIELD_BITS-1:0]  rsp_read_value,
   output logic [BYTES_BITS-1:0]       rsp_read_bytes,
   output logic [ENTRY_COUNT_BITS-1:0] rsp_entry_count
);

   // Latched request.
   logic                     mode_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   logic [BYTES_BITS-1:0]    bytes_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [SLOT_IDX_BITS-1:0] idx_ff;
   logic [SLOT_IDX_BITS-1:0] idx_in;

   // Slot store.
   logic [SLOTS-1:0]         valid_ff;
   logic [SLOTS-1:0]         valid_in;
   logic [KEY_BITS-1:0]      slot_key_ff    [SLOTS];
   logic [VALUE_BITS-1:0]    slot_value_ff  [SLOTS];
   logic [BYTES_BITS-1:0]    slot_bytes_ff  [SLOTS];
   logic [EXPIRY_BITS-1:0]   slot_expiry_ff [SLOTS];
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;

   // Result register.
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   status_type                  rsp_status_ff;
   logic [DATA_FIELD_BITS-1:0]  rsp_value_ff;
   logic [BYTES_BITS-1:0]       rsp_bytes_ff;
   logic [ENTRY_COUNT_BITS-1:0] rsp_count_ff;

   // Evaluation of the current slot.
   logic       req_bad;
   logic       cur_valid;
   logic       cur_expired;
   logic       found;
   logic       last;
   logic       do_add;
   logic       do_remove;
   status_type outcome;

   assign req_bad     = (mode_ff == MODE_ADD) &&
                        ((bytes_ff == '0) || (bytes_ff > BYTES_BITS'(VALUE_BYTES)));
   assign cur_valid   = valid_ff[idx_ff];
   assign cur_expired = slot_expiry_ff[idx_ff] <= {1'b0, now_ff};
   assign last        = idx_ff == SLOT_IDX_BITS'(SLOTS - 1);

   always_comb begin
      if (mode_ff == MODE_ADD) begin
         found = !cur_valid || cur_expired;
      end else begin
         found = cur_valid && (slot_key_ff[idx_ff] == key_ff);
      end
   end

   // Outcome of the request if it finishes on this slot.
   always_comb begin
      if (req_bad) begin
         outcome = STATUS_INVALID;
      end else if (mode_ff == MODE_ADD) begin
         outcome = found ? STATUS_ADDED : STATUS_FULL;
      end else if (found) begin
         outcome = cur_expired ? STATUS_EXPIRED : STATUS_HIT;
      end else begin
         outcome = STATUS_MISS;
      end
   end

   assign do_add    = cmd.commit && (outcome == STATUS_ADDED);
   assign do_remove = cmd.commit && (outcome == STATUS_EXPIRED);

   assign stat.finish   = req_bad || found || last;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // Request latch; the stored value is masked to its byte count here.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         key_ff   <= req_lookup_key[KEY_BITS-1:0];
         value_ff <= req_data_word[VALUE_BITS-1:0] & byte_mask(req_value_bytes);
         bytes_ff <= req_value_bytes;
         now_ff   <= req_now_time;
      end
   end

   // Scan index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Valid bits and entry count.
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (do_add) begin
         valid_in[idx_ff] = 1'b1;
         if (!cur_valid) begin
            count_in = count_ff + 1'b1;
         end
      end else if (do_remove) begin
         valid_in[idx_ff] = 1'b0;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Slot payload writes.
   always_ff @(posedge clock) begin
      if (do_add) begin
         slot_key_ff[idx_ff]    <= key_ff;
         slot_value_ff[idx_ff]  <= value_ff;
         slot_bytes_ff[idx_ff]  <= bytes_ff;
         slot_expiry_ff[idx_ff] <= {1'b0, now_ff} + {1'b0, ttl_seconds};
      end else if (do_remove) begin
         slot_expiry_ff[idx_ff] <= '0;
      end
   end

   // Result register.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= outcome;
         rsp_count_ff  <= ENTRY_COUNT_BITS'(count_in);
         if (outcome == STATUS_HIT) begin
            rsp_value_ff <= DATA_FIELD_BITS'(slot_value_ff[idx_ff]);
            rsp_bytes_ff <= slot_bytes_ff[idx_ff];
         end else begin
            rsp_value_ff <= '0;
            rsp_bytes_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_read_bytes  = rsp_bytes_ff;
   assign rsp_entry_count = rsp_count_ff;

   // The entry count always tracks the number of set valid bits.
   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_BITS'($countones(valid_ff)))
      else $error("entry count differs from valid bits");

   // A commit never lands on a result that is still waiting.
   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("commit while result register is occupied");

   // A commit only happens on a finished scan.
   a_commit_when_finished: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.finish)
      else $error("commit before the scan finished");

   // A hit always carries a nonzero byte count.
   a_hit_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && outcome == STATUS_HIT) |=> rsp_bytes_ff != '0)
      else $error("hit returned with zero byte count");

endmodule

// ----- rtl/ttl_key_value_table.sv -----
// ----------------------------------------------------------------------------
// TTL key/value table
// The scan of the slot store visits one slot per cycle and holds on the
// finishing slot while a waiting response beat is not taken. One request
// is handled at a time: a new request beat is accepted only after the
// outcome of the previous one is committed to the result register.
// Reset clears all valid bits and the entry count at once, with no clearing
// pass, and sets the lifetime register to zero.
// ----------------------------------------------------------------------------
module ttl_key_value_table import ttl_kvt_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [KEY_FIELD_BITS-1:0]   req_lookup_key,
   input  logic [DATA_FIELD_BITS-1:0]  req_data_word,
   input  logic [BYTES_BITS-1:0]       req_value_bytes,
   input  logic [TIME_BITS-1:0]        req_now_time,
   // Response channel.
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [DATA_FIELD_BITS-1:0]  rsp_read_value,
   output logic [BYTES_BITS-1:0]       rsp_read_bytes,
   output logic [ENTRY_COUNT_BITS-1:0] rsp_entry_count,
   // Configuration port.
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                        csr_pready
);

   logic [TIME_BITS-1:0] ttl_ff;
   logic [TIME_BITS-1:0] ttl_in;
   logic                 csr_wr;
   ctrl_cmd_type         cmd;
   dp_stat_type          stat;

   // Lifetime register, written on the access phase of a write.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ttl_in = ttl_ff;
      if (csr_wr && (csr_paddr[CSR_ADDR_BITS-1] == CSR_REG_TTL)) begin
         ttl_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= '0;
      end else begin
         ttl_ff <= ttl_in;
      end
   end

   // Read back; addresses beyond the register list read as zero.
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == CSR_REG_TTL) ? ttl_ff : '0;

   ttl_kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttl_kvt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_lookup_key  (req_lookup_key),
      .req_data_word   (req_data_word),
      .req_value_bytes (req_value_bytes),
      .req_now_time    (req_now_time),
      .ttl_seconds     (ttl_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_read_bytes  (rsp_read_bytes),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
